FILE: sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg : shared types and constants for the bounded deque
// Slot geometry, operation codes, controller states and the command bundle
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

	// ring geometry; DEPTH is a power of two so pointers wrap by truncation
	localparam int DEPTH      = 128;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = PTR_W + 1;
	localparam int DATA_W     = 32;
	localparam int CAP_W      = 8;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	// register map
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);
	localparam logic             REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		OP_ENQ_BACK  = 2'd0,
		OP_DEQ_FRONT = 2'd1,
		OP_DEQ_BACK  = 2'd2,
		OP_PRIO_FRONT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_READ = 3'b100
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic accept;  // latch the incoming beat
		logic exec;    // update pointers, count and slot store
		logic rd;      // read the front slot
		logic done;    // present the result
	} cmd_t;

endpackage

`default_nettype wire

FILE: sv/bounded_deque_with_priority_insert.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_priority_insert : bounded deque of 32-bit tags
// Ring buffer queue with back enqueue, front and back dequeue and a priority insert at the front.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op and item_tag with start high; the beat is taken
//   at the clock edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with front_item, front_valid,
//   entry_count, rejected and evicted; the receiver cannot hold it off.
//   Sequence: after the accepting edge each beat steps through execute,
//   front-slot read through the registered memory port, and the strobe.
//   A new beat is not taken while one is in flight; busy drops in the strobe
//   cycle so the next beat can be taken while the result is shown. The
//   front slot goes through the single read port of the slot memory, read
//   only after the pointer update has been written back.
//   Configuration: APB register capacity at byte address 0 (reset 100), which
//   the user writes only while idle (unenforced); effective limit saturates at 128.
//   Reset: arst_n clears pointer, count and flags; the queue starts empty.
//   Slot memory needs no clearing pass; unwritten slots are never shown.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_priority_insert
	import bdq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [DATA_W-1:0] item_tag,
	output logic                   done,
	output logic [DATA_W-1:0]      front_item,
	output logic                   front_valid,
	output logic [7:0]             entry_count,
	output logic                   rejected,
	output logic                   evicted,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	cmd_t             cmd;
	logic [CAP_W-1:0] capacity;

	bdq_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	bdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	bdq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.item_tag    (item_tag),
		.capacity    (capacity),
		.front_item  (front_item),
		.front_valid (front_valid),
		.entry_count (entry_count),
		.rejected    (rejected),
		.evicted     (evicted),
		.done        (done)
	);

endmodule

`default_nettype wire

FILE: sv/bdq_regs.sv
// ----------------------------------------------------------------------------
// bdq_regs : APB configuration register
// Holds the capacity register; writes complete in the access phase.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_regs
	import bdq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [CAP_W-1:0]  capacity
);

	logic [CAP_W-1:0] capacity_q;
	logic             wr_en;
	logic             reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (wr_en && reg_idx == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// read mux; unaligned low address bits are ignored
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_CAPACITY) begin
			prdata = APB_DW'(capacity_q);
		end
	end

	assign capacity = capacity_q;

endmodule

`default_nettype wire

FILE: sv/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl : operation sequencer
// Steps each accepted beat through execute and front-slot read, then strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl
	import bdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output cmd_t      cmd
);

	state_t state_q, state_nxt;
	logic   done_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_EXEC;
			end
			ST_EXEC: state_nxt = ST_READ;
			ST_READ: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == ST_READ);
		end
	end

	// the strobe cycle is idle, so a new beat may be taken during it
	assign busy       = (state_q != ST_IDLE);
	assign cmd.accept = (state_q == ST_IDLE) & start;
	assign cmd.exec   = (state_q == ST_EXEC);
	assign cmd.rd     = (state_q == ST_READ);
	assign cmd.done   = done_q;

`ifndef SYNTHESIS
	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_READ))
		else $error("result strobe without a preceding read");
`endif

endmodule

`default_nettype wire

FILE: sv/bdq_dpath.sv
// ----------------------------------------------------------------------------
// bdq_dpath : ring buffer datapath
// Slot memory, front pointer, occupancy, flags and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_dpath
	import bdq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [1:0]        op,
	input  wire logic [DATA_W-1:0] item_tag,
	input  wire logic [CAP_W-1:0]  capacity,
	output logic [DATA_W-1:0]      front_item,
	output logic                   front_valid,
	output logic [7:0]             entry_count,
	output logic                   rejected,
	output logic                   evicted,
	output logic                   done
);

	logic [DATA_W-1:0] mem [DEPTH];

	op_t               op_q;
	logic [DATA_W-1:0] tag_q;
	logic [PTR_W-1:0]  fp_q, fp_nxt;
	logic [CNT_W-1:0]  occ_q, occ_nxt;
	logic              rej_q, ev_q, rej_nxt, ev_nxt;
	logic [DATA_W-1:0] rdata_q;
	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;

	logic [CNT_W-1:0]  limit;
	logic              full;
	logic [CNT_W-1:0]  occ_ev;

	// effective capacity saturates at the ring depth
	assign limit = ((CNT_W+CAP_W)'(capacity) > (CNT_W+CAP_W)'(DEPTH)) ?
		CNT_W'(DEPTH) : CNT_W'(capacity);
	assign full  = (occ_q >= limit);

	// operation decode
	always_comb begin
		fp_nxt  = fp_q;
		occ_nxt = occ_q;
		rej_nxt = 1'b0;
		ev_nxt  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = fp_q + occ_q[PTR_W-1:0];
		occ_ev  = occ_q;
		unique case (op_q)
			OP_ENQ_BACK: begin
				if (full || occ_q >= CNT_W'(DEPTH)) begin
					rej_nxt = 1'b1;
				end else begin
					wr_en   = 1'b1;
					occ_nxt = occ_q + 1'b1;
				end
			end
			OP_DEQ_FRONT: begin
				if (occ_q != '0) begin
					fp_nxt  = fp_q + 1'b1;
					occ_nxt = occ_q - 1'b1;
				end
			end
			OP_DEQ_BACK: begin
				if (occ_q != '0) occ_nxt = occ_q - 1'b1;
			end
			OP_PRIO_FRONT: begin
				// drop the back entry first when full, then insert at the front
				if (full && occ_q != '0) begin
					ev_nxt = 1'b1;
					occ_ev = occ_q - 1'b1;
				end
				occ_nxt = occ_ev;
				if (occ_ev < CNT_W'(DEPTH)) begin
					fp_nxt  = fp_q - 1'b1;
					wr_addr = fp_q - 1'b1;
					wr_en   = 1'b1;
					occ_nxt = occ_ev + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q  <= '0;
			occ_q <= '0;
			rej_q <= 1'b0;
			ev_q  <= 1'b0;
		end else if (cmd.exec) begin
			fp_q  <= fp_nxt;
			occ_q <= occ_nxt;
			rej_q <= rej_nxt;
			ev_q  <= ev_nxt;
		end
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(op);
			tag_q <= item_tag;
		end
	end

	// slot store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) mem[wr_addr] <= tag_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rdata_q <= mem[fp_q];
	end

	// result fields
	assign front_valid = (occ_q != '0);
	assign front_item  = front_valid ? rdata_q : '0;
	assign entry_count = 8'(occ_q);
	assign rejected    = rej_q;
	assign evicted     = ev_q;
	assign done        = cmd.done;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond ring depth");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rej_q && ev_q))
		else $error("reject and evict flagged together");
	a_occ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(occ_q) && $stable(fp_q))
		else $error("pointer state moved outside execute");
`endif

endmodule

`default_nettype wire
